// ===== rtl/ctf_pkg.sv =====
// Shared types, constants and encodings for the currency text formatter.
`timescale 1ns / 1ps
`default_nettype none

package ctf_pkg;

  localparam int MAG_W                = 64;
  localparam int NUM_BCD              = 20;
  localparam int NUM_WHOLE            = NUM_BCD - 2;
  localparam int DP_W                 = $clog2(NUM_WHOLE);
  localparam int BCD_IDX_W            = $clog2(NUM_BCD);
  localparam int CNT_W                = $clog2(MAG_W);
  localparam int DEF_MAX_WHOLE_DIGITS = 16;

  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_POINT  = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CONV,
    ST_CHECK,
    ST_SCAN,
    ST_SIGN,
    ST_DOLLAR,
    ST_DIGIT,
    ST_COMMA,
    ST_POINT,
    ST_CENT_HI,
    ST_CENT_LO
  } ctf_state_e;

  typedef enum logic [2:0] {
    SEL_ERR,
    SEL_MINUS,
    SEL_DOLLAR,
    SEL_DIGIT,
    SEL_COMMA,
    SEL_POINT,
    SEL_CENT_HI,
    SEL_CENT_LO
  } ctf_sel_e;

  typedef struct packed {
    logic     load;
    logic     shift;
    logic     scan_dec;
    logic     dig_dec;
    logic     out_valid;
    logic     out_last;
    logic     out_err;
    ctf_sel_e sel;
  } ctf_cmd_t;

  typedef struct packed {
    logic conv_done;
    logic scan_stop;
    logic dp_zero;
    logic grp_zero;
    logic too_big;
    logic neg;
  } ctf_status_t;

endpackage

`default_nettype wire

// ===== rtl/currency_text_formatter_unit.sv =====
// Top level of the currency text formatter: controller, datapath and checks.
//
// Usage: drive amount_cents_i (signed cents) and raise start_i; the transaction
// is taken at the rising edge where start_i is high and busy_o is low. busy_o
// then stays high until the last character has been sent.
// Each character appears on char_code_o for exactly one cycle with
// char_valid_o high; last_char_o marks the final one. The receiver cannot
// stall, so every character must be taken in the cycle it is shown.
// The magnitude is shifted through the shift-and-add-3 converter into 20 BCD
// digits, then the digit limit is checked. A rejected amount gives a single
// character with too_big_o and last_char_o set in the cycle of that check.
// Otherwise a leading-zero scan skips the leading zero whole digits, always
// keeping the units digit, and then one character follows per cycle.
// Reset returns the controller to idle; no transaction is in progress after it.
`timescale 1ns / 1ps
`default_nettype none

module currency_text_formatter_unit #(
  parameter int MAX_WHOLE_DIGITS = ctf_pkg::DEF_MAX_WHOLE_DIGITS
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             start_i,
  output logic                            busy_o,
  input  wire signed [ctf_pkg::MAG_W-1:0] amount_cents_i,
  output logic                            char_valid_o,
  output logic [7:0]                      char_code_o,
  output logic                            last_char_o,
  output logic                            too_big_o
);
  import ctf_pkg::*;

  ctf_cmd_t    cmd;
  ctf_status_t status;

  ctf_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  ctf_dpath #(
    .MAX_WHOLE_DIGITS (MAX_WHOLE_DIGITS)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .amount_cents_i (amount_cents_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .char_valid_o   (char_valid_o),
    .char_code_o    (char_code_o),
    .last_char_o    (last_char_o),
    .too_big_o      (too_big_o)
  );

  a_valid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    char_valid_o |-> busy_o)
    else $error("character strobe outside a transaction");

  a_err_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    too_big_o |-> (char_valid_o && last_char_o && char_code_o == 8'h00))
    else $error("error result malformed");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted transaction did not raise busy");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (char_valid_o && last_char_o) |=> !busy_o)
    else $error("busy remained high after the last character");

endmodule

`default_nettype wire

// ===== rtl/ctf_ctrl.sv =====
// Controller state machine sequencing conversion, scan and character output.
`timescale 1ns / 1ps
`default_nettype none

module ctf_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 start_i,
  input  ctf_pkg::ctf_status_t status_i,
  output ctf_pkg::ctf_cmd_t    cmd_o,
  output logic                busy_o
);
  import ctf_pkg::*;

  ctf_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) state_d = ST_CONV;
      end
      ST_CONV: begin
        if (status_i.conv_done) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        state_d = status_i.too_big ? ST_IDLE : ST_SCAN;
      end
      ST_SCAN: begin
        if (status_i.scan_stop) state_d = status_i.neg ? ST_SIGN : ST_DOLLAR;
      end
      ST_SIGN:   state_d = ST_DOLLAR;
      ST_DOLLAR: state_d = ST_DIGIT;
      ST_DIGIT: begin
        if (status_i.dp_zero) begin
          state_d = ST_POINT;
        end else if (status_i.grp_zero) begin
          state_d = ST_COMMA;
        end
      end
      ST_COMMA:   state_d = ST_DIGIT;
      ST_POINT:   state_d = ST_CENT_HI;
      ST_CENT_HI: state_d = ST_CENT_LO;
      ST_CENT_LO: state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.sel       = SEL_ERR;
    busy_o          = 1'b1;
    case (state_q)
      ST_IDLE: begin
        busy_o     = 1'b0;
        cmd_o.load = start_i;
      end
      ST_CONV: begin
        cmd_o.shift = 1'b1;
      end
      ST_CHECK: begin
        if (status_i.too_big) begin
          cmd_o.out_valid = 1'b1;
          cmd_o.out_last  = 1'b1;
          cmd_o.out_err   = 1'b1;
        end
      end
      ST_SCAN: begin
        cmd_o.scan_dec = !status_i.scan_stop;
      end
      ST_SIGN: begin
        cmd_o.out_valid = 1'b1;
        cmd_o.sel       = SEL_MINUS;
      end
      ST_DOLLAR: begin
        cmd_o.out_valid = 1'b1;
        cmd_o.sel       = SEL_DOLLAR;
      end
      ST_DIGIT: begin
        cmd_o.out_valid = 1'b1;
        cmd_o.sel       = SEL_DIGIT;
        cmd_o.dig_dec   = !status_i.dp_zero && !status_i.grp_zero;
      end
      ST_COMMA: begin
        cmd_o.out_valid = 1'b1;
        cmd_o.sel       = SEL_COMMA;
        cmd_o.dig_dec   = 1'b1;
      end
      ST_POINT: begin
        cmd_o.out_valid = 1'b1;
        cmd_o.sel       = SEL_POINT;
      end
      ST_CENT_HI: begin
        cmd_o.out_valid = 1'b1;
        cmd_o.sel       = SEL_CENT_HI;
      end
      ST_CENT_LO: begin
        cmd_o.out_valid = 1'b1;
        cmd_o.out_last  = 1'b1;
        cmd_o.sel       = SEL_CENT_LO;
      end
      default: begin
        busy_o = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/ctf_dpath.sv =====
// Datapath: magnitude register, shift-and-add-3 BCD converter and character mux.
`timescale 1ns / 1ps
`default_nettype none

module ctf_dpath #(
  parameter int MAX_WHOLE_DIGITS = ctf_pkg::DEF_MAX_WHOLE_DIGITS
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire signed [ctf_pkg::MAG_W-1:0] amount_cents_i,
  input  ctf_pkg::ctf_cmd_t               cmd_i,
  output ctf_pkg::ctf_status_t            status_o,
  output logic                           char_valid_o,
  output logic [7:0]                     char_code_o,
  output logic                           last_char_o,
  output logic                           too_big_o
);
  import ctf_pkg::*;

  localparam logic [DP_W-1:0] DP_TOP  = DP_W'(NUM_WHOLE - 1);
  localparam logic [1:0]      GRP_TOP = 2'((NUM_WHOLE - 1) % 3);

  logic [MAG_W-1:0] mag_q;
  logic [3:0]       bcd_q [NUM_BCD];
  logic [3:0]       bcd_adj [NUM_BCD];
  logic [CNT_W-1:0] cnt_q;
  logic [DP_W-1:0]  dp_q;
  logic [1:0]       grp_q;
  logic             neg_q;
  logic [BCD_IDX_W-1:0] widx;
  logic [3:0]       cur_digit;
  logic             big;

  always_comb begin
    for (int i = 0; i < NUM_BCD; i++) begin
      bcd_adj[i] = (bcd_q[i] >= 4'd5) ? bcd_q[i] + 4'd3 : bcd_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      dp_q  <= '0;
      grp_q <= '0;
      neg_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        cnt_q <= '0;
        dp_q  <= DP_TOP;
        grp_q <= GRP_TOP;
        neg_q <= amount_cents_i[MAG_W-1];
      end else begin
        if (cmd_i.shift) cnt_q <= cnt_q + 1'b1;
        if (cmd_i.scan_dec || cmd_i.dig_dec) begin
          dp_q  <= dp_q - 1'b1;
          grp_q <= (grp_q == 2'd0) ? 2'd2 : grp_q - 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mag_q <= amount_cents_i[MAG_W-1] ? MAG_W'(-amount_cents_i) : MAG_W'(amount_cents_i);
      for (int i = 0; i < NUM_BCD; i++) begin
        bcd_q[i] <= '0;
      end
    end else if (cmd_i.shift) begin
      mag_q    <= {mag_q[MAG_W-2:0], 1'b0};
      bcd_q[0] <= {bcd_adj[0][2:0], mag_q[MAG_W-1]};
      for (int i = 1; i < NUM_BCD; i++) begin
        bcd_q[i] <= {bcd_adj[i][2:0], bcd_adj[i-1][3]};
      end
    end
  end

  assign widx      = BCD_IDX_W'(dp_q) + BCD_IDX_W'(2);
  assign cur_digit = bcd_q[widx];

  always_comb begin
    big = 1'b0;
    for (int i = 0; i < NUM_BCD; i++) begin
      if (i >= MAX_WHOLE_DIGITS + 2 && bcd_q[i] != 4'd0) big = 1'b1;
    end
  end

  assign status_o.conv_done = (cnt_q == CNT_W'(MAG_W - 1));
  assign status_o.scan_stop = (dp_q == '0) || (cur_digit != 4'd0);
  assign status_o.dp_zero   = (dp_q == '0);
  assign status_o.grp_zero  = (grp_q == 2'd0);
  assign status_o.too_big   = big;
  assign status_o.neg       = neg_q;

  always_comb begin
    case (cmd_i.sel)
      SEL_ERR:     char_code_o = 8'h00;
      SEL_MINUS:   char_code_o = CH_MINUS;
      SEL_DOLLAR:  char_code_o = CH_DOLLAR;
      SEL_DIGIT:   char_code_o = CH_ZERO | {4'h0, cur_digit};
      SEL_COMMA:   char_code_o = CH_COMMA;
      SEL_POINT:   char_code_o = CH_POINT;
      SEL_CENT_HI: char_code_o = CH_ZERO | {4'h0, bcd_q[1]};
      SEL_CENT_LO: char_code_o = CH_ZERO | {4'h0, bcd_q[0]};
      default:     char_code_o = 8'h00;
    endcase
  end

  assign char_valid_o = cmd_i.out_valid;
  assign last_char_o  = cmd_i.out_last;
  assign too_big_o    = cmd_i.out_err;

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// Testbench for the currency text formatter: directed and random amounts against a predictor.
`timescale 1ns / 1ps

module tb_top;
  import ctf_pkg::*;

  localparam int MAX_DIGITS   = DEF_MAX_WHOLE_DIGITS;
  localparam int DRAIN_CYCLES = 150;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
    logic       big;
  } text_char_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    start_i = 1'b0;
  logic signed [MAG_W-1:0] amount_cents_i = '0;
  logic                    busy_o;
  logic                    char_valid_o;
  logic [7:0]              char_code_o;
  logic                    last_char_o;
  logic                    too_big_o;

  text_char_t expected_text[$];
  int unsigned mismatches = 0;
  int unsigned amounts_sent = 0;
  int unsigned chars_checked = 0;
  int unsigned amounts_rejected = 0;

  currency_text_formatter_unit u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .amount_cents_i (amount_cents_i),
    .char_valid_o   (char_valid_o),
    .char_code_o    (char_code_o),
    .last_char_o    (last_char_o),
    .too_big_o      (too_big_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic [63:0] pow10(input int unsigned n);
    logic [63:0] p;
    p = 64'd1;
    for (int i = 0; i < n; i++) p = p * 64'd10;
    return p;
  endfunction

  function automatic void push_char(input logic [7:0] code, input logic last);
    expected_text.push_back('{code, last, 1'b0});
  endfunction

  function automatic void format_amount(input logic [63:0] amt);
    logic        neg;
    logic [63:0] mag;
    logic [63:0] whole;
    int unsigned cents;
    int unsigned nd;
    int unsigned digs[20];
    neg   = amt[63];
    mag   = neg ? (64'd0 - amt) : amt;
    whole = mag / 64'd100;
    cents = 32'(mag % 64'd100);
    if (whole >= pow10(MAX_DIGITS)) begin
      expected_text.push_back('{8'h00, 1'b1, 1'b1});
      return;
    end
    nd = 0;
    do begin
      digs[nd] = 32'(whole % 64'd10);
      whole    = whole / 64'd10;
      nd++;
    end while (whole != 64'd0);
    if (neg) push_char(CH_MINUS, 1'b0);
    push_char(CH_DOLLAR, 1'b0);
    for (int i = nd - 1; i >= 0; i--) begin
      push_char(CH_ZERO + 8'(digs[i]), 1'b0);
      if (i > 0 && (i % 3) == 0) push_char(CH_COMMA, 1'b0);
    end
    push_char(CH_POINT, 1'b0);
    push_char(CH_ZERO + 8'(cents / 10), 1'b0);
    push_char(CH_ZERO + 8'(cents % 10), 1'b1);
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("%0t ns: mismatch in %s: got 0x%02h, expected 0x%02h", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    text_char_t want;
    if (rst_ni && char_valid_o === 1'b1) begin
      chars_checked++;
      if (too_big_o === 1'b1) amounts_rejected++;
      if (expected_text.size() == 0) begin
        report_mismatch("unexpected character", char_code_o, 8'h00);
      end else begin
        want = expected_text.pop_front();
        if (char_code_o !== want.code) report_mismatch("char_code", char_code_o, want.code);
        if (last_char_o !== want.last) report_mismatch("last_char", 8'(last_char_o), 8'(want.last));
        if (too_big_o !== want.big) report_mismatch("too_big", 8'(too_big_o), 8'(want.big));
      end
    end
  end

  // The amount stays on the port until the transaction is taken.
  task automatic send_amount(input logic [63:0] amt, input int unsigned idle_pct);
    int unsigned gap;
    gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 8) : 0;
    if (gap > 0) begin
      start_i <= 1'b0;
      while (gap > 0) begin
        @(posedge clk_i);
        if (busy_o === 1'b0) gap--;
      end
    end
    start_i        <= 1'b1;
    amount_cents_i <= amt;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    format_amount(amt);
    amounts_sent++;
  endtask

  task automatic wait_for_text();
    start_i <= 1'b0;
    while (expected_text.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [63:0] pick_amount();
    logic [63:0] raw;
    int unsigned sel;
    sel = $urandom_range(99);
    raw = {$urandom, $urandom};
    if (sel < 60) begin
      raw = raw % pow10($urandom_range(1, 19));
    end else if (sel < 80) begin
      raw = pow10($urandom_range(1, 19)) - 64'd3 + 64'($urandom_range(0, 6));
    end
    if (sel < 80 && $urandom_range(1) == 1) raw = 64'd0 - raw;
    return raw;
  endfunction

  task automatic test_directed_amounts();
    logic [63:0] list[$];
    list = '{64'd0, 64'd1, -64'sd1, -64'sd5, 64'd99, 64'd100, -64'sd100,
             64'd999999, 64'd100000, 64'd123456789, -64'sd123456789,
             64'd999999999999999999, -64'sd999999999999999999,
             64'd1000000000000000000, -64'sd1000000000000000000,
             64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
             64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
             64'd100000000000000000, 64'd99999999999999999};
    foreach (list[i]) send_amount(list[i], 0);
    wait_for_text();
  endtask

  task automatic test_random_amounts(input int unsigned count, input int unsigned idle_pct);
    repeat (count) send_amount(pick_amount(), idle_pct);
    wait_for_text();
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_amounts();
    test_random_amounts(150, 0);
    test_random_amounts(150, 57);
    test_random_amounts(150, 10);
    $display("Sent %0d amounts (%0d rejected as too large) and checked %0d characters.",
             amounts_sent, amounts_rejected, chars_checked);
    $display("Sender gaps were exercised at rates of none, 57 and 10 in a hundred.");
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Run timed out with %0d characters still expected.", expected_text.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== currency_text_formatter_unit.f =====
rtl/ctf_pkg.sv
rtl/ctf_ctrl.sv
rtl/ctf_dpath.sv
rtl/currency_text_formatter_unit.sv
test/tb_top.sv
